FILE: hw/rtl/fdc_pkg.sv
// Package for the FLC frame decoder: parser state codes, shared types and constants.
// Used by the interfaces, the parser, the pixel writer and the top level.
package fdc_pkg;

	localparam int unsigned POS_W   = 17;
	localparam logic [16:0] POS_MAX = 17'h1FFFF;
	localparam logic [10:0] ROW_MAX = 11'd2047;
	localparam int unsigned WR_W    = 22;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned DIM_W   = 11;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// Input opcodes and result kinds.
	localparam logic OP_DATA   = 1'b0;
	localparam logic OP_READ   = 1'b1;
	localparam logic KIND_PAL  = 1'b0;
	localparam logic KIND_PIX  = 1'b1;

	// Sub-chunk types.
	localparam logic [15:0] T_DELTA = 16'h0007;
	localparam logic [15:0] T_COLOR = 16'h000b;
	localparam logic [15:0] T_CLEAR = 16'h000d;
	localparam logic [15:0] T_FULL  = 16'h000f;
	localparam logic [15:0] T_LAST  = 16'h0010;
	localparam logic [15:0] T_NEG   = 16'h8000;

	typedef enum logic [18:0] {
		ST_IDLE     = 19'h00001,
		ST_FRAME_HDR= 19'h00002,
		ST_SUB_HDR  = 19'h00004,
		ST_SKIP     = 19'h00008,
		ST_D_LINES  = 19'h00010,
		ST_D_WORD   = 19'h00020,
		ST_D_SKIP   = 19'h00040,
		ST_D_COUNT  = 19'h00080,
		ST_D_FILL1  = 19'h00100,
		ST_D_FILL2  = 19'h00200,
		ST_D_COPY   = 19'h00400,
		ST_P_COUNT  = 19'h00800,
		ST_P_SKIP   = 19'h01000,
		ST_P_NUM    = 19'h02000,
		ST_P_RGB    = 19'h04000,
		ST_F_PKT    = 19'h08000,
		ST_F_COUNT  = 19'h10000,
		ST_F_FILL   = 19'h20000,
		ST_F_COPY   = 19'h40000
	} parse_state_t;

	// Run command from the parser to the pixel writer.
	typedef struct packed {
		logic            valid;
		logic [WR_W-1:0] start;
		logic [WR_W-1:0] count;
		logic [7:0]      c0;
		logic [7:0]      c1;
		logic            alt;
		logic            sat;
	} wr_cmd_t;

	// Palette entry produced by the parser.
	typedef struct packed {
		logic       valid;
		logic [7:0] index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pal_t;

endpackage

FILE: hw/rtl/fdc_if.sv
// Handshake interfaces of the FLC frame decoder: input items, result items, configuration.
// Depends on fdc_pkg for the configuration index width.
interface fdc_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [7:0]  data_byte;
	logic        frame_start;
	logic [15:0] pixel_address;
	modport source (output valid, opcode, data_byte, frame_start, pixel_address, input ready);
	modport sink   (input valid, opcode, data_byte, frame_start, pixel_address, output ready);
endinterface

interface fdc_out_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [7:0] palette_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] pixel_value;
	modport source (output valid, result_kind, palette_index, red, green, blue, pixel_value,
		input ready);
	modport sink   (input valid, result_kind, palette_index, red, green, blue, pixel_value,
		output ready);
endinterface

interface fdc_cfg_if import fdc_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [10:0]          data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/fdc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module fdc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hw/rtl/fdc_writer.sv
// Pixel writer: turns a run command into one frame store write per cycle.
// Depends on fdc_pkg for the run command type.
module fdc_writer import fdc_pkg::*; #(
	parameter int unsigned STORE_PIXELS = 65536
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wr_cmd_t                         cmd,
	output logic                            busy,
	output logic                            we,
	output logic [$clog2(STORE_PIXELS)-1:0] waddr,
	output logic [7:0]                      wdata
);
	localparam int unsigned AW = $clog2(STORE_PIXELS);

	logic [WR_W-1:0] pos_q;
	logic [WR_W-1:0] cnt_q;
	logic [7:0]      c0_q;
	logic [7:0]      c1_q;
	logic            alt_q;
	logic            odd_q;
	logic            sat_q;

	assign busy  = (cnt_q != '0);
	assign we    = busy && (32'(pos_q) < 32'(STORE_PIXELS));
	assign waddr = pos_q[AW-1:0];
	assign wdata = (alt_q && odd_q) ? c1_q : c0_q;

	// Run counter; the position sticks at the top when saturating.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			odd_q <= 1'b0;
		end else if (cmd.valid) begin
			cnt_q <= cmd.count;
			odd_q <= 1'b0;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			odd_q <= ~odd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid) begin
			pos_q <= cmd.start;
			c0_q  <= cmd.c0;
			c1_q  <= cmd.c1;
			alt_q <= cmd.alt;
			sat_q <= cmd.sat;
		end else if (busy) begin
			if (!(sat_q && pos_q == WR_W'(POS_MAX))) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end
endmodule

FILE: hw/rtl/fdc_parser.sv
// Chunk parser: walks frame, sub-chunk, delta, palette and byte-run data one byte at a time.
// Depends on fdc_pkg; issues run commands to fdc_writer and palette entries to the top level.
module fdc_parser import fdc_pkg::*; #(
	parameter int unsigned STORE_PIXELS = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       b,
	input  logic             fs,
	input  logic [DIM_W-1:0] width,
	input  logic [DIM_W-1:0] height,
	output logic             rowpos_busy,
	output wr_cmd_t          cmd,
	output pal_t             pal
);
	parse_state_t st_q, n_st;
	logic [3:0]  phase_q, n_phase;
	logic [15:0] acc_q, n_acc;
	logic [15:0] sub_q, n_sub;
	logic [31:0] hdr_q, n_hdr;
	logic [15:0] cmd_q, n_cmd;
	logic [15:0] rows_q, n_rows;
	logic [16:0] wpos_q, n_wpos;
	logic [10:0] rowb_q, n_rowb;
	logic [8:0]  run_q, n_run;
	logic [7:0]  c0_q, n_c0;
	logic [8:0]  slot_q, n_slot;
	logic [7:0]  red_q, n_red;
	logic [7:0]  grn_q, n_grn;
	logic [10:0] pkts_q, n_pkts;
	logic [10:0] line_q, n_line;
	logic        pend_q, n_pend;

	logic [21:0] row_prod;
	logic [21:0] area;

	function automatic logic [16:0] sat_add(input logic [16:0] p, input logic [8:0] n);
		logic [17:0] s;
		s = 18'(p) + 18'(n);
		return (s > 18'(POS_MAX)) ? POS_MAX : s[16:0];
	endfunction

	assign rowpos_busy = pend_q;
	assign row_prod    = 22'(rowb_q) * 22'(width);
	assign area        = 22'(width) * 22'(height);

	// Next-state logic for one data item, then the shared end-of-run chains.
	always_comb begin
		parse_state_t cur;
		logic [3:0]  ph;
		logic [15:0] w;
		logic [16:0] mag;
		logic [14:0] rsum;
		logic [8:0]  r;
		logic        sub_done, line_end, pkt_done, run_end, row_end;
		cur = fs ? ST_FRAME_HDR : st_q;
		ph  = fs ? 4'd0 : phase_q;
		w   = {b, acc_q[7:0]};
		mag = 17'h10000 - 17'(w);
		rsum = '0;
		r    = '0;
		sub_done = 1'b0; line_end = 1'b0; pkt_done = 1'b0; run_end = 1'b0; row_end = 1'b0;
		n_st = st_q; n_phase = phase_q; n_acc = acc_q; n_sub = sub_q; n_hdr = hdr_q;
		n_cmd = cmd_q; n_rows = rows_q; n_wpos = wpos_q; n_rowb = rowb_q; n_run = run_q;
		n_c0 = c0_q; n_slot = slot_q; n_red = red_q; n_grn = grn_q; n_pkts = pkts_q;
		n_line = line_q; n_pend = 1'b0;
		cmd = '0;
		pal = '0;
		if (pend_q) begin
			n_wpos = (row_prod > 22'(POS_MAX)) ? POS_MAX : row_prod[16:0];
		end
		if (step) begin
			n_st = cur;
			n_phase = ph;
			case (cur)
				ST_FRAME_HDR: begin
					if (ph == 4'd0) begin
						n_acc = 16'(b);
					end else if (ph == 4'd1) begin
						n_acc = w;
						n_sub = w[15] ? 16'd0 : w;
					end
					n_phase = ph + 1'b1;
					if (ph == 4'd9) begin
						n_phase = '0;
						n_st = (n_sub == '0) ? ST_IDLE : ST_SUB_HDR;
					end
				end
				ST_SUB_HDR: begin
					n_phase = ph + 1'b1;
					case (ph)
						4'd0: n_hdr = 32'(b);
						4'd1: n_hdr = {hdr_q[31:16], b, hdr_q[7:0]};
						4'd2: n_hdr = {hdr_q[31:24], b, hdr_q[15:0]};
						4'd3: n_hdr = {b, hdr_q[23:0]};
						4'd4: n_cmd = 16'(b);
						default: begin
							n_cmd = {b, cmd_q[7:0]};
							// Dispatch on the sub-chunk type.
							if (n_cmd > T_LAST && n_cmd < T_NEG) begin
								n_st = ST_IDLE;
							end else begin
								n_wpos = '0;
								n_rowb = '0;
								n_phase = '0;
								if (n_cmd == T_DELTA) begin
									n_st = ST_D_LINES;
								end else if (n_cmd == T_COLOR) begin
									n_slot = '0;
									n_st = ST_P_COUNT;
								end else if (n_cmd == T_CLEAR) begin
									cmd.valid = 1'b1;
									cmd.start = '0;
									cmd.count = (area > 22'(STORE_PIXELS)) ?
										22'(STORE_PIXELS) : area;
									n_hdr = 32'd6;
									n_st = ST_SKIP;
								end else if (n_cmd == T_FULL) begin
									if (height == '0) begin
										sub_done = 1'b1;
									end else begin
										n_rows = 16'(height);
										n_st = ST_F_PKT;
									end
								end else begin
									n_hdr = (hdr_q > 32'd6 && !hdr_q[31]) ?
										hdr_q - 32'd6 : 32'd0;
									if (n_hdr == '0) sub_done = 1'b1;
									else n_st = ST_SKIP;
								end
							end
						end
					endcase
				end
				ST_SKIP: begin
					n_hdr = hdr_q - 1'b1;
					if (n_hdr == '0) sub_done = 1'b1;
				end
				ST_D_LINES, ST_P_COUNT: begin
					if (ph == 4'd0) begin
						n_acc = 16'(b);
						n_phase = 4'd1;
					end else begin
						n_acc = w;
						n_phase = '0;
						if (w[15] || w == '0 ||
							(cur == ST_D_LINES && w > 16'(height))) begin
							sub_done = 1'b1;
						end else begin
							n_rows = w;
							n_st = (cur == ST_D_LINES) ? ST_D_WORD : ST_P_SKIP;
						end
					end
				end
				ST_D_WORD: begin
					if (ph == 4'd0) begin
						n_acc = 16'(b);
						n_phase = 4'd1;
					end else begin
						n_acc = w;
						n_phase = '0;
						if (w[15]) begin
							if (w[14]) begin
								if (mag >= 17'(height)) begin
									sub_done = 1'b1;
								end else begin
									rsum = 15'(rowb_q) + 15'(mag[13:0]);
									n_rowb = (rsum > 15'(ROW_MAX)) ? ROW_MAX : rsum[10:0];
									n_pend = 1'b1;
								end
							end
						end else if (w > 16'(width)) begin
							sub_done = 1'b1;
						end else if (w == '0) begin
							line_end = 1'b1;
						end else begin
							n_pkts = w[10:0];
							n_st = ST_D_SKIP;
						end
					end
				end
				ST_D_SKIP: begin
					n_wpos = sat_add(wpos_q, 9'(b));
					n_st = ST_D_COUNT;
				end
				ST_D_COUNT: begin
					if (b[7]) begin
						r = 9'd256 - 9'(b);
						n_run = {r[7:0], 1'b0};
						n_st = ST_D_FILL1;
					end else if (b == '0) begin
						pkt_done = 1'b1;
					end else begin
						n_run = {b, 1'b0};
						n_st = ST_D_COPY;
					end
				end
				ST_D_FILL1: begin
					n_c0 = b;
					n_st = ST_D_FILL2;
				end
				ST_D_FILL2: begin
					cmd.valid = 1'b1;
					cmd.start = WR_W'(wpos_q);
					cmd.count = WR_W'(run_q);
					cmd.c0 = c0_q;
					cmd.c1 = b;
					cmd.alt = 1'b1;
					cmd.sat = 1'b1;
					n_wpos = sat_add(wpos_q, run_q);
					n_run = '0;
					pkt_done = 1'b1;
				end
				ST_D_COPY, ST_F_COPY: begin
					cmd.valid = 1'b1;
					cmd.start = WR_W'(wpos_q);
					cmd.count = WR_W'(1);
					cmd.c0 = b;
					cmd.sat = 1'b1;
					n_wpos = sat_add(wpos_q, 9'd1);
					n_run = run_q - 1'b1;
					if (cur == ST_D_COPY) begin
						if (n_run == '0) pkt_done = 1'b1;
					end else begin
						n_line = line_q - 1'b1;
						if (n_run == '0) run_end = 1'b1;
					end
				end
				ST_P_SKIP: begin
					n_slot = slot_q + 9'(b);
					n_st = ST_P_NUM;
				end
				ST_P_NUM: begin
					n_run = (b == '0) ? 9'd256 : 9'(b);
					n_phase = '0;
					n_st = ST_P_RGB;
				end
				ST_P_RGB: begin
					n_phase = ph + 1'b1;
					if (ph == 4'd0) begin
						n_red = b;
					end else if (ph == 4'd1) begin
						n_grn = b;
					end else begin
						n_phase = '0;
						pal.valid = 1'b1;
						pal.index = slot_q[7:0];
						pal.red = red_q;
						pal.green = grn_q;
						pal.blue = b;
						n_slot = slot_q + 1'b1;
						n_run = run_q - 1'b1;
						if (n_run == '0) begin
							n_rows = rows_q - 1'b1;
							if (n_rows == '0) sub_done = 1'b1;
							else n_st = ST_P_SKIP;
						end
					end
				end
				ST_F_PKT: begin
					n_line = width;
					if (width == '0) row_end = 1'b1;
					else n_st = ST_F_COUNT;
				end
				ST_F_COUNT: begin
					if (b[7]) begin
						r = 9'd256 - 9'(b);
						n_run = (11'(r) > line_q) ? 9'(line_q) : r;
						n_st = ST_F_COPY;
					end else begin
						n_run = (11'(b) < line_q) ? 9'(b) : 9'(line_q);
						n_st = ST_F_FILL;
					end
				end
				ST_F_FILL: begin
					cmd.valid = (run_q != '0);
					cmd.start = WR_W'(wpos_q);
					cmd.count = WR_W'(run_q);
					cmd.c0 = b;
					cmd.sat = 1'b1;
					n_wpos = sat_add(wpos_q, run_q);
					n_line = line_q - 11'(run_q);
					n_run = '0;
					run_end = 1'b1;
				end
				default: begin
				end
			endcase
			// Delta packet, delta line, byte-run, row and sub-chunk end chains.
			if (pkt_done) begin
				n_pkts = pkts_q - 1'b1;
				if (n_pkts == '0) line_end = 1'b1;
				else n_st = ST_D_SKIP;
			end
			if (line_end) begin
				n_rowb = (rowb_q < ROW_MAX) ? rowb_q + 1'b1 : ROW_MAX;
				n_pend = 1'b1;
				n_rows = rows_q - 1'b1;
				n_phase = '0;
				if (n_rows == '0) sub_done = 1'b1;
				else n_st = ST_D_WORD;
			end
			if (run_end) begin
				if (n_line == '0) row_end = 1'b1;
				else n_st = ST_F_COUNT;
			end
			if (row_end) begin
				n_rows = rows_q - 1'b1;
				if (n_rows == '0) sub_done = 1'b1;
				else n_st = ST_F_PKT;
			end
			if (sub_done) begin
				n_sub = sub_q - 1'b1;
				n_phase = '0;
				n_st = (n_sub == '0) ? ST_IDLE : ST_SUB_HDR;
			end
		end
	end

	// Parser registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			phase_q <= '0; acc_q <= '0; sub_q <= '0; hdr_q <= '0; cmd_q <= '0;
			rows_q <= '0; wpos_q <= '0; rowb_q <= '0; run_q <= '0; c0_q <= '0;
			slot_q <= '0; red_q <= '0; grn_q <= '0; pkts_q <= '0; line_q <= '0;
			pend_q <= 1'b0;
		end else begin
			st_q <= n_st;
			phase_q <= n_phase; acc_q <= n_acc; sub_q <= n_sub; hdr_q <= n_hdr;
			cmd_q <= n_cmd; rows_q <= n_rows; wpos_q <= n_wpos; rowb_q <= n_rowb;
			run_q <= n_run; c0_q <= n_c0; slot_q <= n_slot; red_q <= n_red;
			grn_q <= n_grn; pkts_q <= n_pkts; line_q <= n_line; pend_q <= n_pend;
		end
	end
endmodule

FILE: hw/rtl/flc_frame_decoder.sv
// Top level of the FLC frame decoder: configuration, frame store, read path, result register.
// Depends on fdc_pkg, fdc_if, fdc_ram, fdc_writer and fdc_parser.
//
//  channel   modport  carries
//  stream    sink     opcode, data_byte, frame_start, pixel_address
//  result    source   result_kind, palette_index, red, green, blue, pixel_value
//  cfg       sink     index, data (frame_width, frame_height)
//
// A data item that starts a run, fill or clear holds off further items while the writer
// writes its pixels (the frame store has one write port), and a line end or row skip holds
// off further items while the row address is recomputed with the multiplier.
// A pixel read holds off further items while it goes through the registered read port.
// Reset clears the parser and sets the configuration to 320 by 200; the frame store is not cleared.
// A result waiting in the output register holds off every further item until it is taken.
module flc_frame_decoder import fdc_pkg::*; #(
	parameter int unsigned STORE_PIXELS = 65536
) (
	input  logic    clk,
	input  logic    arst_n,
	fdc_in_if.sink  stream,
	fdc_out_if.source result,
	fdc_cfg_if.sink cfg
);
	localparam int unsigned AW = $clog2(STORE_PIXELS);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             acc;
	logic             step;
	logic             rowpos_busy;
	logic             wr_busy;
	wr_cmd_t          cmd;
	pal_t             pal;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [7:0]       wdata;
	logic [AW-1:0]    raddr;
	logic [7:0]       rdata;
	logic             rd_pend_q;
	logic             rd_zero_q;
	logic             out_v_q;
	logic             kind_q;
	logic [7:0]       idx_q, red_q, grn_q, blu_q, pix_q;

	// Configuration registers.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd320;
			height_q <= 11'd200;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FRAME_WIDTH:  width_q  <= cfg.data;
				REG_FRAME_HEIGHT: height_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Input handshake.
	assign stream.ready = !wr_busy && !rowpos_busy && !rd_pend_q &&
		(!out_v_q || result.ready);
	assign acc  = stream.valid && stream.ready;
	assign step = acc && (stream.opcode == OP_DATA);

	fdc_parser #(.STORE_PIXELS(STORE_PIXELS)) u_parser (
		.clk(clk), .arst_n(arst_n), .step(step), .b(stream.data_byte),
		.fs(stream.frame_start), .width(width_q), .height(height_q),
		.rowpos_busy(rowpos_busy), .cmd(cmd), .pal(pal)
	);

	fdc_writer #(.STORE_PIXELS(STORE_PIXELS)) u_writer (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .busy(wr_busy),
		.we(we), .waddr(waddr), .wdata(wdata)
	);

	assign raddr = AW'(stream.pixel_address);

	fdc_ram #(.WIDTH(8), .DEPTH(STORE_PIXELS)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// Pixel read in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= acc && (stream.opcode == OP_READ);
		end
	end
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_zero_q <= !(32'(stream.pixel_address) < 32'(STORE_PIXELS));
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (pal.valid || rd_pend_q) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (pal.valid) begin
			kind_q <= KIND_PAL;
			idx_q <= pal.index;
			red_q <= pal.red;
			grn_q <= pal.green;
			blu_q <= pal.blue;
			pix_q <= '0;
		end else if (rd_pend_q) begin
			kind_q <= KIND_PIX;
			idx_q <= '0;
			red_q <= '0;
			grn_q <= '0;
			blu_q <= '0;
			pix_q <= rd_zero_q ? 8'd0 : rdata;
		end
	end

	assign result.valid         = out_v_q;
	assign result.result_kind   = kind_q;
	assign result.palette_index = idx_q;
	assign result.red           = red_q;
	assign result.green         = grn_q;
	assign result.blue          = blu_q;
	assign result.pixel_value   = pix_q;
endmodule
